>>> rtl/lew_pkg.sv
// Shared types and constants of the line editor with word wrap.
`default_nettype none

package lew_pkg;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [1:0] REG_ERASE  = 2'd0;
  localparam logic [1:0] REG_KILL   = 2'd1;
  localparam logic [1:0] REG_WERASE = 2'd2;
  localparam logic [1:0] REG_END    = 2'd3;

  localparam logic [7:0] ERASE_RST  = 8'd127;
  localparam logic [7:0] KILL_RST   = 8'd21;
  localparam logic [7:0] WERASE_RST = 8'd23;
  localparam logic [7:0] END_RST    = 8'd4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    OP_PRINT  = 3'd0,
    OP_ERASE  = 3'd1,
    OP_KILL   = 3'd2,
    OP_WERASE = 3'd3,
    OP_END    = 3'd4,
    OP_BEL    = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  function automatic logic [7:0] fix_byte(op_t op, logic [2:0] step);
    logic [7:0] b;
    b = CH_NUL;
    case (op)
      OP_ERASE: b = (step == 3'd1) ? CH_SP : CH_BS;
      OP_KILL: begin
        case (step)
          3'd0:    b = CH_ESC;
          3'd1:    b = CH_LBR;
          3'd2:    b = CH_TWO;
          3'd3:    b = CH_K;
          default: b = CH_CR;
        endcase
      end
      OP_BEL:  b = CH_BEL;
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

  function automatic logic [2:0] fix_last(op_t op);
    logic [2:0] s;
    case (op)
      OP_ERASE: s = 3'd2;
      OP_KILL:  s = 3'd4;
      default:  s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/lew_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lew_ram #(
  parameter int W = 7,
  parameter int D = 40
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [$clog2(D)-1:0] wr_addr,
  input  logic [W-1:0]         wr_data,
  input  logic                 rd_en,
  input  logic [$clog2(D)-1:0] rd_addr,
  output logic [W-1:0]         rd_data
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lew_front.sv
// Front end: control registers, input classification and the command queue.
`default_nettype none

module lew_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lew_pkg::CFG_AW-1:0] paddr,
  input  logic [lew_pkg::CFG_DW-1:0] pwdata,
  output logic [lew_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output logic                       q_valid,
  output lew_pkg::cmd_t              q_head,
  input  logic                       q_pop
);

  import lew_pkg::*;

  localparam int QAW = $clog2(CMDQ_DEPTH);
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  logic [7:0]     erase_r, erase_nxt;
  logic [7:0]     kill_r, kill_nxt;
  logic [7:0]     werase_r, werase_nxt;
  logic [7:0]     endc_r, endc_nxt;
  cmd_t           q_r [CMDQ_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QCW-1:0] qn_r, qn_nxt;
  logic           cfg_wr;
  logic           push_ok;
  logic           pop_ok;
  cmd_t           cmd;
  logic [7:0]     rd_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign full    = (qn_r == QCW'(CMDQ_DEPTH));
  assign q_valid = (qn_r != '0);
  assign q_head  = q_r[rp_r];
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && q_valid;
  assign prdata  = {{(CFG_DW-8){1'b0}}, rd_sel};

  always_comb begin
    unique case (paddr[3:2])
      REG_ERASE:  rd_sel = erase_r;
      REG_KILL:   rd_sel = kill_r;
      REG_WERASE: rd_sel = werase_r;
      REG_END:    rd_sel = endc_r;
      default:    rd_sel = 8'h00;
    endcase
  end

  always_comb begin
    erase_nxt  = erase_r;
    kill_nxt   = kill_r;
    werase_nxt = werase_r;
    endc_nxt   = endc_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ERASE:  erase_nxt  = pwdata[7:0];
        REG_KILL:   kill_nxt   = pwdata[7:0];
        REG_WERASE: werase_nxt = pwdata[7:0];
        REG_END:    endc_nxt   = pwdata[7:0];
        default:    erase_nxt  = erase_r;
      endcase
    end
  end

  always_comb begin
    cmd.ch = in_byte;
    if (in_byte >= CH_SP && in_byte <= CH_TILDE) begin
      cmd.op = OP_PRINT;
    end else if (in_byte == erase_r) begin
      cmd.op = OP_ERASE;
    end else if (in_byte == kill_r) begin
      cmd.op = OP_KILL;
    end else if (in_byte == werase_r) begin
      cmd.op = OP_WERASE;
    end else if (in_byte == endc_r) begin
      cmd.op = OP_END;
    end else begin
      cmd.op = OP_BEL;
    end
  end

  always_comb begin
    wp_nxt = push_ok ? wp_r + QAW'(1) : wp_r;
    rp_nxt = pop_ok ? rp_r + QAW'(1) : rp_r;
    qn_nxt = qn_r;
    if (push_ok && !pop_ok) begin
      qn_nxt = qn_r + QCW'(1);
    end else if (!push_ok && pop_ok) begin
      qn_nxt = qn_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_r  <= ERASE_RST;
      kill_r   <= KILL_RST;
      werase_r <= WERASE_RST;
      endc_r   <= END_RST;
      wp_r     <= '0;
      rp_r     <= '0;
      qn_r     <= '0;
    end else begin
      erase_r  <= erase_nxt;
      kill_r   <= kill_nxt;
      werase_r <= werase_nxt;
      endc_r   <= endc_nxt;
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      qn_r     <= qn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/lew_back.sv
// Back end: line store, word scans, wrap and echo sequencing, result register.
`default_nettype none

module lew_back #(
  parameter int LINE_LEN = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  lew_pkg::cmd_t q_head,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_session_end
);

  import lew_pkg::*;

  localparam int CW = $clog2(LINE_LEN + 1);
  localparam int AW = $clog2(LINE_LEN);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCANB = 8'b0000_0010,
    S_SCANF = 8'b0000_0100,
    S_CSI   = 8'b0000_1000,
    S_LF    = 8'b0001_0000,
    S_MOVE  = 8'b0010_0000,
    S_ECHO  = 8'b0100_0000,
    S_FIX   = 8'b1000_0000
  } state_t;

  state_t      state_r, state_nxt;
  op_t         op_r, op_nxt;
  logic [7:0]  ch_r, ch_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        ended_r, ended_nxt;
  logic [CW-1:0] ws_r, ws_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] mi_r, mi_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic        iss_r, iss_nxt;
  logic        chk_r, chk_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic        psp_r, psp_nxt;
  logic        have_r, have_nxt;
  logic        wrap_r, wrap_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic        os_r, os_nxt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [6:0]    rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [6:0]    wr_data;

  logic        em_ok;
  logic        em;
  logic [7:0]  em_byte;
  logic        em_last;
  logic        em_sess;

  logic [6:0]  n7;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones7;
  logic [CW-1:0] src;
  logic [CW-1:0] lastpos;
  logic [CW-1:0] ws_b;
  logic [CW-1:0] ws_f;
  logic        is_sp;

  lew_ram #(.W(7), .D(LINE_LEN)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign em_ok   = !ov_r || pop;
  assign n7      = 7'(n_r);
  assign prod    = 15'(n7) * 15'd205;
  assign tens    = prod[14:11];
  assign ones7   = n7 - 7'(tens) * 7'd10;
  assign src     = ws_r + mi_r;
  assign lastpos = cnt_r - CW'(1);
  assign ws_b    = CW'(pos_r) + CW'(1);
  assign is_sp   = (rd_data == CH_SP[6:0]);
  assign ws_f    = (!is_sp && psp_r) ? CW'(pos_r) : ws_r;

  assign empty           = !ov_r;
  assign out_byte        = ob_r;
  assign out_last        = ol_r;
  assign out_session_end = os_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    ended_nxt = ended_r;
    ws_nxt    = ws_r;
    n_nxt     = n_r;
    mi_nxt    = mi_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    iss_nxt   = iss_r;
    chk_nxt   = chk_r;
    pos_nxt   = pos_r;
    psp_nxt   = psp_r;
    have_nxt  = have_r;
    wrap_nxt  = wrap_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_r[AW-1:0];
    wr_data   = ch_r[6:0];
    em        = 1'b0;
    em_byte   = CH_NUL;
    em_last   = 1'b0;
    em_sess   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          ch_nxt   = q_head.ch;
          op_nxt   = q_head.op;
          step_nxt = '0;
          if (!ended_r) begin
            unique case (q_head.op)
              OP_PRINT: begin
                if (cnt_r == CW'(LINE_LEN)) begin
                  idx_nxt   = AW'(LINE_LEN - 1);
                  iss_nxt   = 1'b1;
                  chk_nxt   = 1'b0;
                  state_nxt = S_SCANB;
                end else begin
                  state_nxt = S_ECHO;
                end
              end
              OP_ERASE: begin
                if (cnt_r != '0) begin
                  cnt_nxt   = cnt_r - CW'(1);
                  state_nxt = S_FIX;
                end
              end
              OP_KILL: begin
                cnt_nxt   = '0;
                state_nxt = S_FIX;
              end
              OP_WERASE: begin
                wrap_nxt = 1'b0;
                ws_nxt   = '0;
                if (cnt_r == '0) begin
                  n_nxt     = '0;
                  state_nxt = S_CSI;
                end else begin
                  idx_nxt   = '0;
                  iss_nxt   = 1'b1;
                  chk_nxt   = 1'b0;
                  psp_nxt   = 1'b1;
                  state_nxt = S_SCANF;
                end
              end
              OP_END: begin
                if (cnt_r == '0) begin
                  ended_nxt = 1'b1;
                  state_nxt = S_FIX;
                end
              end
              OP_BEL:  state_nxt = S_FIX;
              default: state_nxt = S_IDLE;
            endcase
          end
        end
      end

      S_SCANB: begin
        rd_en   = iss_r;
        chk_nxt = iss_r;
        if (iss_r) begin
          pos_nxt = idx_r;
          if (idx_r == '0) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r - AW'(1);
          end
        end
        if (chk_r && (is_sp || pos_r == '0)) begin
          iss_nxt  = 1'b0;
          chk_nxt  = 1'b0;
          step_nxt = '0;
          if (is_sp && ws_b != CW'(LINE_LEN)) begin
            ws_nxt    = ws_b;
            n_nxt     = CW'(LINE_LEN) - ws_b;
            wrap_nxt  = 1'b1;
            state_nxt = S_CSI;
          end else begin
            wrap_nxt  = 1'b0;
            state_nxt = S_LF;
          end
        end
      end

      S_SCANF: begin
        rd_en   = iss_r;
        chk_nxt = iss_r;
        if (iss_r) begin
          pos_nxt = idx_r;
          if (CW'(idx_r) == lastpos) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
        if (chk_r) begin
          ws_nxt  = ws_f;
          psp_nxt = is_sp;
          if (CW'(pos_r) == lastpos) begin
            chk_nxt   = 1'b0;
            n_nxt     = cnt_r - ws_f;
            cnt_nxt   = ws_f;
            step_nxt  = '0;
            state_nxt = S_CSI;
          end
        end
      end

      S_CSI: begin
        if (em_ok) begin
          em = 1'b1;
          case (step_r)
            3'd0:    em_byte = CH_ESC;
            3'd1:    em_byte = CH_LBR;
            3'd2:    em_byte = CH_ZERO | {4'h0, tens};
            3'd3:    em_byte = CH_ZERO | {4'h0, ones7[3:0]};
            3'd4:    em_byte = CH_D;
            3'd5:    em_byte = CH_ESC;
            3'd6:    em_byte = CH_LBR;
            default: em_byte = CH_K;
          endcase
          if (step_r == 3'd7) begin
            em_last   = !wrap_r;
            state_nxt = wrap_r ? S_LF : S_IDLE;
          end else if (step_r == 3'd1 && tens == 4'd0) begin
            step_nxt = 3'd3;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end

      S_LF: begin
        if (em_ok) begin
          em      = 1'b1;
          em_byte = CH_LF;
          if (wrap_r) begin
            mi_nxt    = '0;
            have_nxt  = 1'b0;
            state_nxt = S_MOVE;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_ECHO;
          end
        end
      end

      S_MOVE: begin
        rd_addr = src[AW-1:0];
        if (!have_r) begin
          rd_en    = 1'b1;
          have_nxt = 1'b1;
        end else if (em_ok) begin
          em      = 1'b1;
          em_byte = {1'b0, rd_data};
          wr_en   = 1'b1;
          wr_addr = mi_r[AW-1:0];
          wr_data = rd_data;
          if (mi_r + CW'(1) == n_r) begin
            have_nxt  = 1'b0;
            cnt_nxt   = n_r;
            state_nxt = S_ECHO;
          end else begin
            mi_nxt  = mi_r + CW'(1);
            rd_en   = 1'b1;
            rd_addr = AW'(src + CW'(1));
          end
        end
      end

      S_ECHO: begin
        if (em_ok) begin
          em        = 1'b1;
          em_byte   = ch_r;
          em_last   = 1'b1;
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_IDLE;
        end
      end

      S_FIX: begin
        if (em_ok) begin
          em      = 1'b1;
          em_byte = fix_byte(op_r, step_r);
          em_sess = (op_r == OP_END);
          if (step_r == fix_last(op_r)) begin
            em_last   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            step_nxt = step_r + 3'd1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    os_nxt = os_r;
    if (pop && ov_r) begin
      ov_nxt = 1'b0;
    end
    if (em) begin
      ov_nxt = 1'b1;
      ob_nxt = em_byte;
      ol_nxt = em_last;
      os_nxt = em_sess;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ended_r <= 1'b0;
      iss_r   <= 1'b0;
      chk_r   <= 1'b0;
      have_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ended_r <= ended_nxt;
      iss_r   <= iss_nxt;
      chk_r   <= chk_nxt;
      have_r  <= have_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    ch_r   <= ch_nxt;
    ws_r   <= ws_nxt;
    n_r    <= n_nxt;
    mi_r   <= mi_nxt;
    step_r <= step_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    psp_r  <= psp_nxt;
    wrap_r <= wrap_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    os_r   <= os_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(LINE_LEN))
    else $error("line count beyond line length");

  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("session end flag dropped");

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} < (AW+1)'(LINE_LEN)))
    else $error("line store write out of range");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && os_r) |-> (ob_r == CH_NUL && ol_r))
    else $error("malformed end marker");

endmodule

`default_nettype wire

>>> rtl/line_editor_word_wrap.sv
// Top level of the line editor with word wrap.
// Keyboard bytes go in through push/full and echo bytes come out one per
// item through empty/pop, each with out_last on the final byte caused by
// an input byte and out_session_end on the end marker. Input bytes are
// classified and queued two deep, so typing can run ahead of the echo.
// A printable byte on a non-full line is dispatched and then echoed;
// erase, kill, bell and end are dispatched and then emit their bytes in
// turn. Word erase walks the line store through its single read port,
// one entry a cycle, before its at most eight bytes. A wrap scans back
// from the end of the line for a space, emits its escape sequence and
// line feed, then moves the word at one character a cycle unless the
// echo output stalls, after a priming read. The output register
// decouples the pop side.
`default_nettype none

module line_editor_word_wrap #(
  parameter int LINE_LEN = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 in_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 out_byte,
  output logic                       out_last,
  output logic                       out_session_end,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lew_pkg::CFG_AW-1:0] paddr,
  input  logic [lew_pkg::CFG_DW-1:0] pwdata,
  output logic [lew_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  import lew_pkg::*;

  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  lew_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_byte (in_byte),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  lew_back #(.LINE_LEN(LINE_LEN)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_session_end (out_session_end)
  );

endmodule

`default_nettype wire
